@@ rtl/dxt5_pkg.sv @@
// Package for the DXT5 block decoder: payload structs, the palette entry
// type that travels between the front and back parts, and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dxt5_pkg;

    localparam int PIXELS_PER_BLOCK = 16;
    localparam int POS_W            = $clog2(PIXELS_PER_BLOCK);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIXELS_PER_BLOCK - 1);

    localparam int ALPHA_IDX_W = 3;
    localparam int COLOR_IDX_W = 2;

    // Channel order inside a color palette entry.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Default depth of the palette queue between front and back.
    localparam int DXT5_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  alpha_end0;
        logic [7:0]  alpha_end1;
        logic [47:0] alpha_codes;
        logic [15:0] color_end0;
        logic [15:0] color_end1;
        logic [31:0] color_codes;
    } dxt5_in_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [POS_W-1:0] pixel_pos;
        logic             last_pixel;
    } dxt5_out_t;

    // One decoded block: both palettes plus the per-pixel indices.
    typedef struct packed {
        logic [7:0][7:0]      apal;
        logic [3:0][2:0][7:0] cpal;
        logic [47:0]          alpha_codes;
        logic [31:0]          color_codes;
    } dxt5_entry_t;

endpackage

`default_nettype wire

@@ rtl/dxt5_front.sv @@
// Front part of the DXT5 decoder: accepts a block, registers the endpoint
// blend sums and finishes both palettes for the queue. Uses dxt5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dxt5_front
    import dxt5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire dxt5_in_t    blk,
    output logic             q_push,
    input  wire logic        q_full,
    output dxt5_entry_t      q_wdata
);

    // Truncating divisions by constants through reciprocal multiplication.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'(2341);
        return prod[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] prod;
        prod = 22'(x) * 22'(1639);
        return prod[20:13];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'(683);
        return prod[18:11];
    endfunction

    logic                  valid_reg, valid_next;
    logic                  accept;
    logic [7:0]            a0_reg, a1_reg;
    logic                  mode8_reg;
    logic [6:1][10:0]      asum_reg, asum_next;
    logic [2:0][7:0]       e0_reg, e1_reg, e0_next, e1_next;
    logic [2:0][9:0]       csum2_reg, csum3_reg, csum2_next, csum3_next;
    logic [47:0]           acodes_reg;
    logic [31:0]           ccodes_reg;

    assign accept = push && !full;
    assign full   = valid_reg && q_full;
    assign q_push = valid_reg && !q_full;

    always_comb
    begin
        int k0;
        int k1;
        for (int i = 1; i <= 6; i++)
        begin
            if (blk.alpha_end0 > blk.alpha_end1)
            begin
                k0 = 7 - i;
                k1 = i;
            end
            else if (i <= 4)
            begin
                k0 = 5 - i;
                k1 = i;
            end
            else
            begin
                k0 = 0;
                k1 = 0;
            end
            asum_next[i] = 11'(k0) * 11'(blk.alpha_end0) + 11'(k1) * 11'(blk.alpha_end1);
        end
    end

    always_comb
    begin
        e0_next[CH_RED]   = {blk.color_end0[15:11], blk.color_end0[15:13]};
        e0_next[CH_GREEN] = {blk.color_end0[10:5],  blk.color_end0[10:9]};
        e0_next[CH_BLUE]  = {blk.color_end0[4:0],   blk.color_end0[4:2]};
        e1_next[CH_RED]   = {blk.color_end1[15:11], blk.color_end1[15:13]};
        e1_next[CH_GREEN] = {blk.color_end1[10:5],  blk.color_end1[10:9]};
        e1_next[CH_BLUE]  = {blk.color_end1[4:0],   blk.color_end1[4:2]};
        for (int ch = 0; ch < 3; ch++)
        begin
            csum2_next[ch] = {1'b0, e0_next[ch], 1'b0} + {2'b0, e1_next[ch]};
            csum3_next[ch] = {2'b0, e0_next[ch]} + {1'b0, e1_next[ch], 1'b0};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a0_reg     <= blk.alpha_end0;
            a1_reg     <= blk.alpha_end1;
            mode8_reg  <= blk.alpha_end0 > blk.alpha_end1;
            asum_reg   <= asum_next;
            e0_reg     <= e0_next;
            e1_reg     <= e1_next;
            csum2_reg  <= csum2_next;
            csum3_reg  <= csum3_next;
            acodes_reg <= blk.alpha_codes;
            ccodes_reg <= blk.color_codes;
        end
    end

    always_comb
    begin
        q_wdata.apal[0] = a0_reg;
        q_wdata.apal[1] = a1_reg;
        if (mode8_reg)
        begin
            for (int i = 1; i <= 6; i++)
            begin
                q_wdata.apal[i+1] = div7(asum_reg[i]);
            end
        end
        else
        begin
            for (int i = 1; i <= 4; i++)
            begin
                q_wdata.apal[i+1] = div5(asum_reg[i]);
            end
            q_wdata.apal[6] = 8'd0;
            q_wdata.apal[7] = 8'd255;
        end
        q_wdata.cpal[0] = e0_reg;
        q_wdata.cpal[1] = e1_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            q_wdata.cpal[2][ch] = div3(csum2_reg[ch]);
            q_wdata.cpal[3][ch] = div3(csum3_reg[ch]);
        end
        q_wdata.alpha_codes = acodes_reg;
        q_wdata.color_codes = ccodes_reg;
    end

endmodule

`default_nettype wire

@@ rtl/dxt5_queue.sv @@
// Short queue of decoded palettes between the front and back parts.
// Uses dxt5_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module dxt5_queue
    import dxt5_pkg::*;
#(
    parameter int DEPTH = DXT5_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire dxt5_entry_t wdata,
    output logic             q_full,
    input  wire logic        rd_en,
    output dxt5_entry_t      rdata,
    output logic             q_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dxt5_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign q_full  = count_reg == CNT_W'(DEPTH);
    assign q_valid = count_reg != '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dxt5_back.sv @@
// Back part of the DXT5 decoder: walks the sixteen pixels of the block at the
// queue head and holds each in an output register. Uses dxt5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dxt5_back
    import dxt5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire dxt5_entry_t head,
    output logic             q_pop,
    output logic             empty,
    input  wire logic        pop,
    output dxt5_out_t        pixel
);

    logic [POS_W-1:0]       cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    dxt5_out_t              pixel_reg, pixel_next;
    logic                   load;
    logic [COLOR_IDX_W-1:0] ci;
    logic [ALPHA_IDX_W-1:0] ai;
    logic [5:0]             abase;

    assign empty = !out_valid_reg;
    assign pixel = pixel_reg;
    assign load  = q_valid && (!out_valid_reg || pop);
    assign q_pop = load && (cnt_reg == LAST_POS);

    assign abase = {2'b0, cnt_reg} + {1'b0, cnt_reg, 1'b0};
    assign ci    = head.color_codes[{cnt_reg, 1'b0} +: COLOR_IDX_W];
    assign ai    = head.alpha_codes[abase +: ALPHA_IDX_W];

    always_comb
    begin
        pixel_next.red        = head.cpal[ci][CH_RED];
        pixel_next.green      = head.cpal[ci][CH_GREEN];
        pixel_next.blue       = head.cpal[ci][CH_BLUE];
        pixel_next.alpha      = head.apal[ai];
        pixel_next.pixel_pos  = cnt_reg;
        pixel_next.last_pixel = cnt_reg == LAST_POS;
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dxt5_block_decoder.sv @@
// Top level of the DXT5 (BC3) block decoder. Instantiates dxt5_front,
// dxt5_queue and dxt5_back; types and constants come from dxt5_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one 16-byte DXT5 block per request on the input queue
// interface and returns sixteen RGBA pixels, one request each, in row-major
// order with the sixteenth pixel flagged by last_pixel. The front part
// registers the block and its blend sums, finishes both palettes in the
// following cycle and writes them into a short palette queue. The back part
// emits one pixel per cycle from the palette at the queue head while pop
// takes them and the queue holds a block. On its way to the output a block
// passes the front registers, a palette queue slot and the output register.
// New blocks are accepted while earlier ones are still being emitted, as long
// as the front register or the palette queue (QUEUE_DEPTH entries) has room.
module dxt5_block_decoder
    import dxt5_pkg::*;
#(
    parameter int QUEUE_DEPTH = DXT5_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire dxt5_in_t blk,
    output logic          empty,
    input  wire logic     pop,
    output dxt5_out_t     pixel
);

    // Handshake between the front part and the palette queue.
    logic        q_push;
    logic        q_full;
    dxt5_entry_t q_wdata;

    // Handshake between the palette queue and the back part.
    logic        q_pop;
    logic        q_valid;
    dxt5_entry_t q_head;

    dxt5_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .blk     (blk),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_wdata (q_wdata)
    );

    dxt5_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rdata   (q_head),
        .q_valid (q_valid)
    );

    dxt5_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .pixel   (pixel)
    );

    // Within a block the next pixel is ready in the cycle after one is taken.
    a_block_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !pixel.last_pixel) |=> !empty)
        else $error("pixel stream of a block stalled");

    // Pixel positions advance by one within a block.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !pixel.last_pixel) |=>
            (pixel.pixel_pos == POS_W'($past(pixel.pixel_pos) + 1'b1)))
        else $error("pixel position skipped");

    // The last-pixel flag marks exactly the final position of the block.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pixel.last_pixel == (pixel.pixel_pos == LAST_POS)))
        else $error("last_pixel does not match pixel position");

    // A finished block always starts the next one at position zero.
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && pixel.last_pixel) ##1 !empty |-> (pixel.pixel_pos == '0))
        else $error("block did not restart at pixel zero");

endmodule

`default_nettype wire
